### rtl/edge_center_snap_selector_assert.svh
// assertion macros shared by the snap selector modules
`ifndef EDGE_CENTER_SNAP_SELECTOR_ASSERT_SVH
`define EDGE_CENTER_SNAP_SELECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition that must hold at every clock edge
`define ECSS_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// implication checked in the same cycle
`define ECSS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define ECSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`else

`define ECSS_ASSERT_ALWAYS(lbl, cond, msg)
`define ECSS_ASSERT_SAME(lbl, ante, cons, msg)
`define ECSS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/ecss_pkg.sv
// shared types and constants of the edge and center snap selector
package ecss_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF   = 4;

   localparam int THRESH_W = 16;
   // biased doubled distance: twice the 16-bit threshold plus the bias
   localparam int DIST_W   = 18;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd128;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD     = 3'd0,
      CSR_CANVAS_LEFT   = 3'd1,
      CSR_CANVAS_TOP    = 3'd2,
      CSR_CANVAS_RIGHT  = 3'd3,
      CSR_CANVAS_BOTTOM = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_MOVING = 1'b0,
      OP_LAYER  = 1'b1
   } op_type;

   // per-axis control from the item stage
   typedef struct packed {
      logic commit;    // item leaves the item stage this cycle
      logic clear;     // new query, drop the kept best
      logic consider;  // item takes part in the selection
      logic canvas;    // targets are the canvas rectangle
      logic bias;      // add the one-pixel layer bias
   } axis_ctrl_type;

endpackage

### rtl/ecss_axis.sv
// one axis: nine pairings, min-select tree and the kept best match
`include "edge_center_snap_selector_assert.svh"

module ecss_axis
   import ecss_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  axis_ctrl_type                 ctrl,
   input  logic [THRESH_W-1:0]           threshold,
   input  logic signed [COORD_WIDTH-1:0] m_lo,
   input  logic signed [COORD_WIDTH-1:0] m_hi,
   input  logic signed [COORD_WIDTH-1:0] t_lo,
   input  logic signed [COORD_WIDTH-1:0] t_hi,
   input  logic signed [COORD_WIDTH-1:0] span_lo,
   input  logic signed [COORD_WIDTH-1:0] span_hi,
   output logic                          nxt_valid,
   output logic signed [COORD_WIDTH:0]   nxt_delta,
   output logic signed [COORD_WIDTH-1:0] nxt_axis,
   output logic signed [COORD_WIDTH-1:0] nxt_lo,
   output logic signed [COORD_WIDTH-1:0] nxt_hi,
   output logic                          nxt_canvas
);

   localparam int W     = COORD_WIDTH;
   localparam int CMP_W = (W + 2 > DIST_W) ? W + 2 : DIST_W;
   localparam logic [DIST_W-1:0] BIAS2 = DIST_W'(2) << FRAC_BITS;

   typedef struct packed {
      logic                valid;
      logic [DIST_W-1:0]   gap;
      logic signed [W:0]   delta;
      logic signed [W-1:0] axis;
   } cand_type;

   function automatic cand_type pick(input cand_type a, input cand_type b);
      // left side wins ties, so the earliest pairing is kept
      if (b.valid && (!a.valid || b.gap < a.gap)) begin
         return b;
      end
      return a;
   endfunction

   logic signed [W:0] m2 [3];
   logic signed [W:0] t2 [3];
   cand_type cand [16];
   cand_type lvl1 [8];
   cand_type lvl2 [4];
   cand_type lvl3 [2];
   cand_type win;

   logic                best_valid_ff, best_valid_in;
   logic [DIST_W-1:0]   best_dist_ff, best_dist_in;
   logic signed [W:0]   best_delta_ff, best_delta_in;
   logic signed [W-1:0] best_axis_ff, best_axis_in;
   logic signed [W-1:0] best_lo_ff, best_lo_in;
   logic signed [W-1:0] best_hi_ff, best_hi_in;
   logic                best_canvas_ff, best_canvas_in;
   logic                base_valid;
   logic                take;

   // doubled positions: low edge, center, high edge
   always_comb begin
      m2[0] = {m_lo, 1'b0};
      m2[1] = (W+1)'(m_lo) + (W+1)'(m_hi);
      m2[2] = {m_hi, 1'b0};
      t2[0] = {t_lo, 1'b0};
      t2[1] = (W+1)'(t_lo) + (W+1)'(t_hi);
      t2[2] = {t_hi, 1'b0};
   end

   // moving position outer, target position inner
   always_comb begin
      logic signed [W+1:0] diff;
      logic [W+1:0]        mag;
      logic [CMP_W-1:0]    lim2;
      lim2 = CMP_W'({threshold, 1'b0});
      for (int k = 0; k < 16; k++) begin
         cand[k] = '0;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            diff = (W+2)'(t2[j]) - (W+2)'(m2[i]);
            mag  = diff[W+1] ? $unsigned(-diff) : $unsigned(diff);
            cand[i*3+j].valid = (CMP_W'(mag) <= lim2);
            cand[i*3+j].gap   = DIST_W'(mag) + (ctrl.bias ? BIAS2 : '0);
            cand[i*3+j].delta = diff[W+1:1];
            cand[i*3+j].axis  = t2[j][W:1];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         lvl1[k] = pick(cand[2*k], cand[2*k+1]);
      end
      for (int k = 0; k < 4; k++) begin
         lvl2[k] = pick(lvl1[2*k], lvl1[2*k+1]);
      end
      for (int k = 0; k < 2; k++) begin
         lvl3[k] = pick(lvl2[2*k], lvl2[2*k+1]);
      end
      win = pick(lvl3[0], lvl3[1]);
   end

   // update against the kept best, which a new query drops
   always_comb begin
      base_valid     = best_valid_ff && !ctrl.clear;
      take           = ctrl.consider && win.valid && (!base_valid || win.gap < best_dist_ff);
      best_valid_in  = base_valid || take;
      best_dist_in   = take ? win.gap    : best_dist_ff;
      best_delta_in  = take ? win.delta  : best_delta_ff;
      best_axis_in   = take ? win.axis   : best_axis_ff;
      best_lo_in     = take ? span_lo    : best_lo_ff;
      best_hi_in     = take ? span_hi    : best_hi_ff;
      best_canvas_in = take ? ctrl.canvas : best_canvas_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
      end else if (ctrl.commit) begin
         best_valid_ff <= best_valid_in;
      end
      if (ctrl.commit) begin
         best_dist_ff   <= best_dist_in;
         best_delta_ff  <= best_delta_in;
         best_axis_ff   <= best_axis_in;
         best_lo_ff     <= best_lo_in;
         best_hi_ff     <= best_hi_in;
         best_canvas_ff <= best_canvas_in;
      end
   end

   // result as it stands after this item, zero when no guide
   assign nxt_valid  = best_valid_in;
   assign nxt_delta  = best_valid_in ? best_delta_in : '0;
   assign nxt_axis   = best_valid_in ? best_axis_in  : '0;
   assign nxt_lo     = best_valid_in ? best_lo_in    : '0;
   assign nxt_hi     = best_valid_in ? best_hi_in    : '0;
   assign nxt_canvas = best_valid_in && best_canvas_in;

   `ECSS_ASSERT_NEXT(a_best_kept, ctrl.commit && best_valid_ff && !ctrl.clear, best_valid_ff, "kept best lost without a new query")
   `ECSS_ASSERT_NEXT(a_dist_shrinks, ctrl.commit && best_valid_ff && !ctrl.clear, best_dist_ff <= $past(best_dist_ff), "kept distance grew within a query")

endmodule

### rtl/edge_center_snap_selector.sv
// top level of the edge and center snap selector
//
// request channel (req_*): one rectangle per transfer. operation 0 opens a
// query with the moving rectangle and matches it against the canvas
// rectangle; operation 1 brings another layer's rectangle. last = 1 marks
// the final item of a query and causes exactly one result transfer.
// result channel (rsp_*): per axis the snap flag, delta, guide position,
// guide span and canvas flag; fields of an axis with no guide are zero.
// csr channel (csr_*): register writes, always ready; write only while idle.
// throughput: one item per cycle while no last item waits on a stalled
// result. a last item's result goes through the item register, then the
// result register, from which it is offered on the result channel.
// the per-item work is nine threshold compares and a four-level min tree on
// each axis between the item register and the kept-best / result registers.
// stall: a stalled result holds in the result register; items that give no
// result keep flowing, and a last item waits in the item register, which
// then raises req_stall. reset clears the query state, the moving rectangle
// and the canvas to zero and sets the threshold to 128.
`include "edge_center_snap_selector_assert.svh"

module edge_center_snap_selector
   import ecss_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   localparam int CSR_DATA_W = (COORD_WIDTH > THRESH_W) ? COORD_WIDTH : THRESH_W
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic                          req_last,
   input  logic signed [COORD_WIDTH-1:0] req_rect_left,
   input  logic signed [COORD_WIDTH-1:0] req_rect_top,
   input  logic signed [COORD_WIDTH-1:0] req_rect_right,
   input  logic signed [COORD_WIDTH-1:0] req_rect_bottom,
   input  logic                          req_layer_visible,
   input  logic                          req_layer_locked,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_has_vertical,
   output logic signed [COORD_WIDTH:0]   rsp_delta_x,
   output logic signed [COORD_WIDTH-1:0] rsp_vertical_axis,
   output logic signed [COORD_WIDTH-1:0] rsp_vertical_span_lo,
   output logic signed [COORD_WIDTH-1:0] rsp_vertical_span_hi,
   output logic                          rsp_vertical_from_canvas,
   output logic                          rsp_has_horizontal,
   output logic signed [COORD_WIDTH:0]   rsp_delta_y,
   output logic signed [COORD_WIDTH-1:0] rsp_horizontal_axis,
   output logic signed [COORD_WIDTH-1:0] rsp_horizontal_span_lo,
   output logic signed [COORD_WIDTH-1:0] rsp_horizontal_span_hi,
   output logic                          rsp_horizontal_from_canvas
);

   localparam int W = COORD_WIDTH;

   // configuration registers
   logic [THRESH_W-1:0] threshold_ff;
   logic signed [W-1:0] canvas_left_ff, canvas_top_ff, canvas_right_ff, canvas_bottom_ff;

   // item register
   logic                s1_valid_ff, s1_valid_in;
   op_type              s1_op_ff;
   logic                s1_last_ff;
   logic signed [W-1:0] s1_left_ff, s1_top_ff, s1_right_ff, s1_bottom_ff;
   logic                s1_visible_ff, s1_locked_ff;

   // moving rectangle of the open query
   logic signed [W-1:0] mov_left_ff, mov_top_ff, mov_right_ff, mov_bottom_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_v_has_ff, out_h_has_ff;
   logic signed [W:0]   out_dx_ff, out_dy_ff;
   logic signed [W-1:0] out_v_axis_ff, out_v_lo_ff, out_v_hi_ff;
   logic signed [W-1:0] out_h_axis_ff, out_h_lo_ff, out_h_hi_ff;
   logic                out_v_canvas_ff, out_h_canvas_ff;

   logic                req_take;
   logic                s1_advance;
   logic                s1_emit;
   logic                is_moving;
   logic                layer_empty;
   logic                layer_used;

   // pairing inputs for each axis
   logic signed [W-1:0] mx_lo, mx_hi, my_lo, my_hi;
   logic signed [W-1:0] tx_lo, tx_hi, ty_lo, ty_hi;
   logic signed [W-1:0] vspan_lo, vspan_hi, hspan_lo, hspan_hi;
   axis_ctrl_type       ctrl;

   logic                v_valid, h_valid, v_canvas, h_canvas;
   logic signed [W:0]   v_delta, h_delta;
   logic signed [W-1:0] v_axis, v_lo, v_hi, h_axis, h_lo, h_hi;

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= THRESH_RESET;
         canvas_left_ff   <= '0;
         canvas_top_ff    <= '0;
         canvas_right_ff  <= '0;
         canvas_bottom_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD:     threshold_ff     <= csr_wdata[THRESH_W-1:0];
            CSR_CANVAS_LEFT:   canvas_left_ff   <= csr_wdata[W-1:0];
            CSR_CANVAS_TOP:    canvas_top_ff    <= csr_wdata[W-1:0];
            CSR_CANVAS_RIGHT:  canvas_right_ff  <= csr_wdata[W-1:0];
            CSR_CANVAS_BOTTOM: canvas_bottom_ff <= csr_wdata[W-1:0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // handshake: only a last item waits, and only on a stalled full result
   // ---------------------------------------------------------------------
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign s1_emit    = s1_advance && s1_last_ff;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_take) begin
         s1_op_ff      <= op_type'(req_operation);
         s1_last_ff    <= req_last;
         s1_left_ff    <= req_rect_left;
         s1_top_ff     <= req_rect_top;
         s1_right_ff   <= req_rect_right;
         s1_bottom_ff  <= req_rect_bottom;
         s1_visible_ff <= req_layer_visible;
         s1_locked_ff  <= req_layer_locked;
      end
   end

   // ---------------------------------------------------------------------
   // item decode: moving rectangle against canvas, or layer against moving
   // ---------------------------------------------------------------------
   assign is_moving   = (s1_op_ff == OP_MOVING);
   assign layer_empty = (s1_right_ff <= s1_left_ff) || (s1_bottom_ff <= s1_top_ff);
   assign layer_used  = s1_visible_ff && !s1_locked_ff && !layer_empty;

   always_comb begin
      if (is_moving) begin
         // the new moving rectangle is used in the same pass
         mx_lo    = s1_left_ff;
         mx_hi    = s1_right_ff;
         my_lo    = s1_top_ff;
         my_hi    = s1_bottom_ff;
         tx_lo    = canvas_left_ff;
         tx_hi    = canvas_right_ff;
         ty_lo    = canvas_top_ff;
         ty_hi    = canvas_bottom_ff;
         vspan_lo = canvas_top_ff;
         vspan_hi = canvas_bottom_ff;
         hspan_lo = canvas_left_ff;
         hspan_hi = canvas_right_ff;
      end else begin
         mx_lo    = mov_left_ff;
         mx_hi    = mov_right_ff;
         my_lo    = mov_top_ff;
         my_hi    = mov_bottom_ff;
         tx_lo    = s1_left_ff;
         tx_hi    = s1_right_ff;
         ty_lo    = s1_top_ff;
         ty_hi    = s1_bottom_ff;
         // layer guide spans cover both rectangles
         vspan_lo = (mov_top_ff < s1_top_ff)       ? mov_top_ff    : s1_top_ff;
         vspan_hi = (mov_bottom_ff > s1_bottom_ff) ? mov_bottom_ff : s1_bottom_ff;
         hspan_lo = (mov_left_ff < s1_left_ff)     ? mov_left_ff   : s1_left_ff;
         hspan_hi = (mov_right_ff > s1_right_ff)   ? mov_right_ff  : s1_right_ff;
      end
   end

   always_comb begin
      ctrl.commit   = s1_advance;
      ctrl.clear    = is_moving;
      ctrl.consider = is_moving || layer_used;
      ctrl.canvas   = is_moving;
      ctrl.bias     = !is_moving;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mov_left_ff   <= '0;
         mov_top_ff    <= '0;
         mov_right_ff  <= '0;
         mov_bottom_ff <= '0;
      end else if (s1_advance && is_moving) begin
         mov_left_ff   <= s1_left_ff;
         mov_top_ff    <= s1_top_ff;
         mov_right_ff  <= s1_right_ff;
         mov_bottom_ff <= s1_bottom_ff;
      end
   end

   // ---------------------------------------------------------------------
   // per-axis selection; x gives the vertical guide, y the horizontal one
   // ---------------------------------------------------------------------
   ecss_axis #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_axis_x (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .threshold  (threshold_ff),
      .m_lo       (mx_lo),
      .m_hi       (mx_hi),
      .t_lo       (tx_lo),
      .t_hi       (tx_hi),
      .span_lo    (vspan_lo),
      .span_hi    (vspan_hi),
      .nxt_valid  (v_valid),
      .nxt_delta  (v_delta),
      .nxt_axis   (v_axis),
      .nxt_lo     (v_lo),
      .nxt_hi     (v_hi),
      .nxt_canvas (v_canvas)
   );

   ecss_axis #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_axis_y (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .threshold  (threshold_ff),
      .m_lo       (my_lo),
      .m_hi       (my_hi),
      .t_lo       (ty_lo),
      .t_hi       (ty_hi),
      .span_lo    (hspan_lo),
      .span_hi    (hspan_hi),
      .nxt_valid  (h_valid),
      .nxt_delta  (h_delta),
      .nxt_axis   (h_axis),
      .nxt_lo     (h_lo),
      .nxt_hi     (h_hi),
      .nxt_canvas (h_canvas)
   );

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   assign rsp_valid_in = s1_emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_emit) begin
         out_v_has_ff    <= v_valid;
         out_dx_ff       <= v_delta;
         out_v_axis_ff   <= v_axis;
         out_v_lo_ff     <= v_lo;
         out_v_hi_ff     <= v_hi;
         out_v_canvas_ff <= v_canvas;
         out_h_has_ff    <= h_valid;
         out_dy_ff       <= h_delta;
         out_h_axis_ff   <= h_axis;
         out_h_lo_ff     <= h_lo;
         out_h_hi_ff     <= h_hi;
         out_h_canvas_ff <= h_canvas;
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_has_vertical           = out_v_has_ff;
   assign rsp_delta_x                = out_dx_ff;
   assign rsp_vertical_axis          = out_v_axis_ff;
   assign rsp_vertical_span_lo       = out_v_lo_ff;
   assign rsp_vertical_span_hi       = out_v_hi_ff;
   assign rsp_vertical_from_canvas   = out_v_canvas_ff;
   assign rsp_has_horizontal         = out_h_has_ff;
   assign rsp_delta_y                = out_dy_ff;
   assign rsp_horizontal_axis        = out_h_axis_ff;
   assign rsp_horizontal_span_lo     = out_h_lo_ff;
   assign rsp_horizontal_span_hi     = out_h_hi_ff;
   assign rsp_horizontal_from_canvas = out_h_canvas_ff;

   `ECSS_ASSERT_SAME(a_stall_cause, req_stall, s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall, "request stalled without a blocked result")
   `ECSS_ASSERT_NEXT(a_last_gives_rsp, s1_emit, rsp_valid, "last item left without a result")
   `ECSS_ASSERT_SAME(a_no_vguide_zero, rsp_valid && !rsp_has_vertical, rsp_delta_x == '0 && rsp_vertical_axis == '0 && !rsp_vertical_from_canvas, "x fields set without a guide")
   `ECSS_ASSERT_SAME(a_no_hguide_zero, rsp_valid && !rsp_has_horizontal, rsp_delta_y == '0 && rsp_horizontal_axis == '0 && !rsp_horizontal_from_canvas, "y fields set without a guide")

endmodule
